/* src/assert_macros.svh */
// Assertion helpers. Each use needs clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("invariant assertion failed");
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication assertion failed");
`else
`define ASSERT_ALWAYS(label, expr)
`define ASSERT_IMPLIES(label, ante, cons)
`endif
`endif

/* src/nasf_pkg.sv */
`default_nettype none
package nasf_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int NORMAL_BITS_DEF   = 16;

  // angle formats: degrees with 20 fraction bits
  localparam int ANG_FRAC = 20;
  localparam int ZW       = 30;  // signed CORDIC angle accumulator
  localparam int AW       = 29;  // wrapped angle, 0 .. 360 deg
  localparam int DSTW     = 28;  // distance, 0 .. 180 deg
  localparam int LIGHT_W  = 9;
  localparam int SHADE_W  = 11;

  localparam logic [LIGHT_W-1:0] LIGHT_RESET = 9'd135;
  localparam logic [LIGHT_W-1:0] DEG_FULL    = 9'd360;

  localparam logic [AW-1:0] ANG_FULL = AW'(360 << ANG_FRAC);
  localparam logic [AW-1:0] ANG_HALF = AW'(180 << ANG_FRAC);

  // shade = floor((NUM_BASE - 7*d) / (225 * 2^13)); the 2^13 is a shift,
  // the 225 is a reciprocal multiply that is exact for the 18-bit quotient
  localparam int NUMW = 31;
  localparam int MW   = 18;
  localparam int KW   = 19;
  localparam int PW   = MW + KW;
  localparam int RECIP_SHIFT = 26;
  localparam logic [NUMW-1:0] NUM_BASE = 31'd1888358400;
  localparam logic [KW-1:0]   RECIP    = 19'd298262;

  localparam logic [SHADE_W-1:0] SHADE_MIN = 11'd307;
  localparam logic [SHADE_W-1:0] SHADE_MAX = 11'd1024;

  typedef struct packed {
    logic signed [ZW-1:0] z;
    logic                 neg;
  } ang_t;

  // atan(2^-i) in degrees, Q20
  function automatic logic signed [ZW-1:0] atan_q20(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:  v = 30'sd47185920;
      5'd1:  v = 30'sd27855475;
      5'd2:  v = 30'sd14718068;
      5'd3:  v = 30'sd7471121;
      5'd4:  v = 30'sd3750058;
      5'd5:  v = 30'sd1876857;
      5'd6:  v = 30'sd938658;
      5'd7:  v = 30'sd469357;
      5'd8:  v = 30'sd234682;
      5'd9:  v = 30'sd117342;
      5'd10: v = 30'sd58671;
      5'd11: v = 30'sd29335;
      5'd12: v = 30'sd14668;
      5'd13: v = 30'sd7334;
      5'd14: v = 30'sd3667;
      5'd15: v = 30'sd1833;
      5'd16: v = 30'sd917;
      5'd17: v = 30'sd458;
      5'd18: v = 30'sd229;
      5'd19: v = 30'sd115;
      5'd20: v = 30'sd57;
      5'd21: v = 30'sd29;
      5'd22: v = 30'sd14;
      5'd23: v = 30'sd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* src/normal_angle_shade_factor.sv */
// Per-vertex shade factor from the xy components of a normal. Each request
// carries normal_x and normal_y (signed Q1.14); the block finds the normal's
// direction over the full circle with a vectoring CORDIC (x of zero is taken
// as 0.01, the left half plane is folded by a 180 degree turn), takes the
// short-way distance d to the light direction set through cfg_light_direction
// (whole degrees, reset 135, values of 360 and up wrap), and returns
// shade = 0.3 + 0.7 * (1 - d/180) in Q1.10, rounded, 307 to 1024. One result
// per request, in order. Throughput is one request per clock unless the
// output stalls. Stages: one input conditioning stage, one CORDIC stage per
// micro-rotation, then angle wrap, distance, scaling and reciprocal multiply
// stages, the last of which is the output register. Every stage holds its own
// valid bit and advances when empty or when its successor moves, so bubbles
// close up under a stalled output and in_ready drops only when every stage is
// full and the output is not taken. Write the light direction only while no
// request is in flight.
`default_nettype none
`include "assert_macros.svh"
module normal_angle_shade_factor #(
  parameter int CORDIC_STAGES = nasf_pkg::CORDIC_STAGES_DEF,
  parameter int NORMAL_BITS   = nasf_pkg::NORMAL_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [nasf_pkg::LIGHT_W-1:0]       cfg_light_direction,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic signed [NORMAL_BITS-1:0]      in_normal_x,
  input  wire logic signed [NORMAL_BITS-1:0]      in_normal_y,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [nasf_pkg::SHADE_W-1:0]            out_shade
);

  // datapath width: input plus sign, CORDIC gain, 2^CORDIC_STAGES scaling
  localparam int DW = NORMAL_BITS + CORDIC_STAGES + 3;

  logic [nasf_pkg::LIGHT_W-1:0] light_r;

  logic                 cv [CORDIC_STAGES+1];
  logic                 cr [CORDIC_STAGES+1];
  logic signed [DW-1:0] cx [CORDIC_STAGES+1];
  logic signed [DW-1:0] cy [CORDIC_STAGES+1];
  nasf_pkg::ang_t       ca [CORDIC_STAGES+1];

  // hold the light direction already reduced modulo 360
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_r <= nasf_pkg::LIGHT_RESET;
    end else if (cfg_we) begin
      if (cfg_light_direction >= nasf_pkg::DEG_FULL) begin
        light_r <= cfg_light_direction - nasf_pkg::DEG_FULL;
      end else begin
        light_r <= cfg_light_direction;
      end
    end
  end

  // zero-x substitution, half-plane fold, scale up
  nasf_prep #(
    .NORMAL_BITS  (NORMAL_BITS),
    .CORDIC_STAGES(CORDIC_STAGES),
    .DW           (DW)
  ) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_x     (in_normal_x),
    .in_y     (in_normal_y),
    .out_valid(cv[0]),
    .out_ready(cr[0]),
    .out_x    (cx[0]),
    .out_y    (cy[0]),
    .out_ang  (ca[0])
  );

  // unrolled CORDIC: one micro-rotation per register stage
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    nasf_cordic_stage #(
      .DW   (DW),
      .STAGE(g)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (cv[g]),
      .in_ready (cr[g]),
      .in_x     (cx[g]),
      .in_y     (cy[g]),
      .in_ang   (ca[g]),
      .out_valid(cv[g+1]),
      .out_ready(cr[g+1]),
      .out_x    (cx[g+1]),
      .out_y    (cy[g+1]),
      .out_ang  (ca[g+1])
    );
  end

  // angle wrap, distance, shade; last stage drives the result ports
  nasf_shade u_shade (
    .clk      (clk),
    .rst_n    (rst_n),
    .light    (light_r),
    .in_valid (cv[CORDIC_STAGES]),
    .in_ready (cr[CORDIC_STAGES]),
    .in_ang   (ca[CORDIC_STAGES]),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_shade(out_shade)
  );

  // stored light direction is always reduced
  `ASSERT_ALWAYS(a_light_reduced, light_r < nasf_pkg::DEG_FULL)
  // a delivered shade lies within 0.3 .. 1.0
  `ASSERT_IMPLIES(a_shade_range, out_valid,
                  out_shade >= nasf_pkg::SHADE_MIN && out_shade <= nasf_pkg::SHADE_MAX)
  // back-pressure at the input only comes from a stalled output
  `ASSERT_IMPLIES(a_ready_cause, !in_ready, out_valid && !out_ready)

endmodule
`default_nettype wire

/* src/nasf_prep.sv */
`default_nettype none
module nasf_prep #(
  parameter int NORMAL_BITS   = nasf_pkg::NORMAL_BITS_DEF,
  parameter int CORDIC_STAGES = nasf_pkg::CORDIC_STAGES_DEF,
  parameter int DW            = NORMAL_BITS + CORDIC_STAGES + 3
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [NORMAL_BITS-1:0] in_x,
  input  wire logic signed [NORMAL_BITS-1:0] in_y,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [DW-1:0]               out_x,
  output logic signed [DW-1:0]               out_y,
  output nasf_pkg::ang_t                     out_ang
);

  localparam int XZERO = ((1 << (NORMAL_BITS - 2)) + 50) / 100;

  logic                          valid_r;
  logic                          load;
  logic signed [NORMAL_BITS:0]   xe, ye, xa, ya;
  logic                          neg;
  logic signed [DW-1:0]          x_r, y_r, x_nxt, y_nxt;
  logic                          neg_r;

  always_comb begin
    xe = {in_x[NORMAL_BITS-1], in_x};
    ye = {in_y[NORMAL_BITS-1], in_y};
    if (in_x == '0) begin
      xe = (NORMAL_BITS + 1)'(XZERO);
    end
    // left half plane: rotate by 180 degrees
    neg = xe[NORMAL_BITS];
    xa  = neg ? -xe : xe;
    ya  = neg ? -ye : ye;
    x_nxt = {{(DW - NORMAL_BITS - 1 - CORDIC_STAGES){xa[NORMAL_BITS]}}, xa,
             {CORDIC_STAGES{1'b0}}};
    y_nxt = {{(DW - NORMAL_BITS - 1 - CORDIC_STAGES){ya[NORMAL_BITS]}}, ya,
             {CORDIC_STAGES{1'b0}}};
  end

  assign load     = !valid_r || out_ready;
  assign in_ready = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      neg_r <= neg;
    end
  end

  assign out_valid   = valid_r;
  assign out_x       = x_r;
  assign out_y       = y_r;
  assign out_ang.z   = '0;
  assign out_ang.neg = neg_r;

endmodule
`default_nettype wire

/* src/nasf_cordic_stage.sv */
`default_nettype none
module nasf_cordic_stage #(
  parameter int DW    = 35,
  parameter int STAGE = 0
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic signed [DW-1:0] in_x,
  input  wire logic signed [DW-1:0] in_y,
  input  nasf_pkg::ang_t            in_ang,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed [DW-1:0]      out_x,
  output logic signed [DW-1:0]      out_y,
  output nasf_pkg::ang_t            out_ang
);

  logic                           valid_r;
  logic                           load;
  logic signed [DW-1:0]           xs, ys;
  logic signed [DW-1:0]           x_r, y_r, x_nxt, y_nxt;
  nasf_pkg::ang_t                 ang_r, ang_nxt;
  logic signed [nasf_pkg::ZW-1:0] step;

  assign step = nasf_pkg::atan_q20(5'(STAGE));

  // one vectoring micro-rotation toward y = 0
  always_comb begin
    xs = in_x >>> STAGE;
    ys = in_y >>> STAGE;
    ang_nxt.neg = in_ang.neg;
    if (!in_y[DW-1]) begin
      x_nxt     = in_x + ys;
      y_nxt     = in_y - xs;
      ang_nxt.z = in_ang.z + step;
    end else begin
      x_nxt     = in_x - ys;
      y_nxt     = in_y + xs;
      ang_nxt.z = in_ang.z - step;
    end
  end

  assign load     = !valid_r || out_ready;
  assign in_ready = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      ang_r <= ang_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_ang   = ang_r;

endmodule
`default_nettype wire

/* src/nasf_shade.sv */
`default_nettype none
module nasf_shade (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic [nasf_pkg::LIGHT_W-1:0]         light,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  nasf_pkg::ang_t                            in_ang,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [nasf_pkg::SHADE_W-1:0]              out_shade
);

  localparam int NST = 4;

  logic [NST-1:0]                  v_r;
  logic [NST-1:0]                  en;
  logic [NST-1:0]                  vin;

  logic signed [nasf_pkg::ZW-1:0]  asum;
  logic [nasf_pkg::AW-1:0]         ang_r, ang_nxt;
  logic [nasf_pkg::AW-1:0]         lig;
  logic signed [nasf_pkg::AW:0]    diff;
  logic [nasf_pkg::AW-1:0]         adiff;
  logic [nasf_pkg::DSTW-1:0]       d_r, d_nxt;
  logic [nasf_pkg::NUMW-1:0]       num;
  logic [nasf_pkg::MW-1:0]         m_r;
  logic [nasf_pkg::PW-1:0]         prod_r;

  // stall chain: a stage loads when empty or when its successor moves
  always_comb begin
    en[NST-1] = !v_r[NST-1] || out_ready;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign vin      = {v_r[NST-2:0], in_valid};
  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (en[i]) begin
          v_r[i] <= vin[i];
        end
      end
    end
  end

  // wrap angle into 0 .. 360
  always_comb begin
    asum = in_ang.z + (in_ang.neg ? $signed({1'b0, nasf_pkg::ANG_HALF})
                                  : $signed(nasf_pkg::ZW'(0)));
    if (asum < 0) begin
      ang_nxt = nasf_pkg::AW'(asum + $signed({1'b0, nasf_pkg::ANG_FULL}));
    end else if (asum >= $signed({1'b0, nasf_pkg::ANG_FULL})) begin
      ang_nxt = nasf_pkg::AW'(asum - $signed({1'b0, nasf_pkg::ANG_FULL}));
    end else begin
      ang_nxt = nasf_pkg::AW'(asum);
    end
  end

  // shortest distance to the light direction
  always_comb begin
    lig   = {light, {nasf_pkg::ANG_FRAC{1'b0}}};
    diff  = $signed({1'b0, ang_r}) - $signed({1'b0, lig});
    adiff = diff[nasf_pkg::AW] ? nasf_pkg::AW'(-diff) : nasf_pkg::AW'(diff);
    if (adiff > nasf_pkg::ANG_HALF) begin
      d_nxt = nasf_pkg::DSTW'(nasf_pkg::ANG_FULL - adiff);
    end else begin
      d_nxt = nasf_pkg::DSTW'(adiff);
    end
  end

  // numerator minus 7*d, then drop the power-of-two part of the divisor
  assign num = nasf_pkg::NUM_BASE - ({d_r, 3'b000} - {3'b000, d_r});

  always_ff @(posedge clk) begin
    if (en[0] && vin[0]) begin
      ang_r <= ang_nxt;
    end
    if (en[1] && vin[1]) begin
      d_r <= d_nxt;
    end
    if (en[2] && vin[2]) begin
      m_r <= num[nasf_pkg::NUMW-1 -: nasf_pkg::MW];
    end
    if (en[3] && vin[3]) begin
      prod_r <= nasf_pkg::PW'(m_r) * nasf_pkg::PW'(nasf_pkg::RECIP);
    end
  end

  assign out_valid = v_r[NST-1];
  assign out_shade = prod_r[nasf_pkg::RECIP_SHIFT +: nasf_pkg::SHADE_W];

endmodule
`default_nettype wire

/* tb/normal_angle_shade_factor_tb.sv */
`default_nettype none
module normal_angle_shade_factor_tb;

  localparam int     STAGES      = nasf_pkg::CORDIC_STAGES_DEF;
  localparam int     NB          = nasf_pkg::NORMAL_BITS_DEF;
  localparam int     LIGHT_W     = nasf_pkg::LIGHT_W;
  localparam int     SHADE_W     = nasf_pkg::SHADE_W;
  localparam int     ANG_FRAC    = nasf_pkg::ANG_FRAC;
  localparam logic [LIGHT_W-1:0] LIGHT_RESET = nasf_pkg::LIGHT_RESET;
  localparam longint ANG_ONE     = 64'sd1 << ANG_FRAC;
  localparam int     CYCLE_LIMIT = 300000;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [LIGHT_W-1:0]     cfg_light_direction = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic signed [NB-1:0]   in_normal_x = '0;
  logic signed [NB-1:0]   in_normal_y = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [SHADE_W-1:0]     out_shade;

  // Expected shade per accepted request, oldest first.
  logic [SHADE_W-1:0]     shade_expect_q[$];
  logic [SHADE_W-1:0]     shade_exp;
  // Our copy of the light direction register.
  logic [LIGHT_W-1:0]     light_deg = LIGHT_RESET;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  // Long receiver hold-off: bump hold_req to start one; hold_len sets its length.
  int hold_req = 0;
  int hold_len = 0;
  int hold_seen = 0;
  int hold_left = 0;

  normal_angle_shade_factor #(
    .CORDIC_STAGES(STAGES),
    .NORMAL_BITS  (NB)
  ) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_light_direction(cfg_light_direction),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_normal_x        (in_normal_x),
    .in_normal_y        (in_normal_y),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_shade          (out_shade)
  );

  always #1 clk = ~clk;

  // Shade predictor: vectoring CORDIC on the normal, fold the left half plane
  // by 180 degrees, wrap into 0..360, take the short-way distance to the
  // light and scale into Q1.10 with round half up.
  function automatic logic [SHADE_W-1:0] predict_shade(input logic signed [NB-1:0] nx,
                                                       input logic signed [NB-1:0] ny,
                                                       input logic [LIGHT_W-1:0] light);
    longint vx, vy, vz, base, ang, lig, d, xs, ys, step, den, num;
    real    pi;
    pi = 4.0 * $atan(1.0);
    vx = nx;
    vy = ny;
    vz = 0;
    base = 0;
    // Replace a zero x by 0.01 in the input format.
    if (vx == 0) vx = ((64'sd1 <<< (NB - 2)) + 50) / 100;
    // Turn left-half-plane vectors by 180 degrees.
    if (vx < 0) begin
      vx = -vx;
      vy = -vy;
      base = 180 * ANG_ONE;
    end
    vx = vx * (64'sd1 <<< STAGES);
    vy = vy * (64'sd1 <<< STAGES);
    for (int i = 0; i < STAGES; i++) begin
      // atan(2^-i) in degrees, Q20, rounded to nearest
      step = $rtoi($atan(1.0 / real'(64'sd1 <<< i)) * 180.0 / pi * real'(ANG_ONE) + 0.5);
      xs = vx >>> i;
      ys = vy >>> i;
      if (vy >= 0) begin
        vx = vx + ys;
        vy = vy - xs;
        vz = vz + step;
      end else begin
        vx = vx - ys;
        vy = vy + xs;
        vz = vz - step;
      end
    end
    ang = base + vz;
    if (ang < 0) ang = ang + 360 * ANG_ONE;
    if (ang >= 360 * ANG_ONE) ang = ang - 360 * ANG_ONE;
    lig = light;
    if (lig >= 360) lig = lig - 360;
    lig = lig * ANG_ONE;
    d = ang - lig;
    if (d < 0) d = -d;
    if (d > 180 * ANG_ONE) d = 360 * ANG_ONE - d;
    den = 225 * ANG_ONE;
    num = 1024 * den - 896 * d + den / 2;
    return SHADE_W'(num / den);
  endfunction

  // Offer one request, optionally after idle cycles, and hold it until taken.
  task automatic send_normal(input logic signed [NB-1:0] nx, input logic signed [NB-1:0] ny);
    while (int'($urandom_range(99)) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_normal_x <= nx;
    in_normal_y <= ny;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    shade_expect_q.push_back(predict_shade(nx, ny, light_deg));
  endtask

  // Drop valid and wait until every expected shade has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (shade_expect_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Write the light direction; call only with the pipeline empty.
  task automatic write_light(input logic [LIGHT_W-1:0] deg);
    cfg_we              <= 1'b1;
    cfg_light_direction <= deg;
    @(posedge clk);
    cfg_we    <= 1'b0;
    light_deg = deg;
  endtask

  // Extremes of both fields, the four axes, zero x, the zero vector and the
  // diagonals, under the light direction left by reset.
  task automatic test_directed_normals();
    send_idle_pct = 20;
    recv_idle_pct = 20;
    send_normal(16'sd16384, 16'sd0);
    send_normal(16'sd0, 16'sd16384);
    send_normal(-16'sd16384, 16'sd0);
    send_normal(16'sd0, -16'sd16384);
    send_normal(16'sd0, 16'sd0);
    send_normal(16'sd0, -16'sd1);
    send_normal(-16'sd1, 16'sd0);
    send_normal(-16'sd1, -16'sd1);
    send_normal(-16'sd32768, -16'sd32768);
    send_normal(16'sd32767, 16'sd32767);
    send_normal(-16'sd32768, 16'sd32767);
    send_normal(16'sd32767, -16'sd32768);
    send_normal(-16'sd11585, 16'sd11585);
    send_normal(16'sd11585, -16'sd11585);
    send_normal(16'sd11585, 16'sd11585);
    drain_results();
  endtask

  // Walk the light register through its extremes, wrapping values included, and aim
  // one normal straight at the light and one straight away from it each time.
  task automatic test_light_settings();
    logic [LIGHT_W-1:0] lights[7];
    real                rad;
    int                 eff;
    lights = '{9'd0, 9'd359, 9'd180, 9'd360, 9'd511, 9'd400, 9'd45};
    foreach (lights[k]) begin
      write_light(lights[k]);
      eff = (lights[k] >= 360) ? int'(lights[k]) - 360 : int'(lights[k]);
      rad = real'(eff) * 4.0 * $atan(1.0) / 180.0;
      send_normal(NB'($rtoi(16384.0 * $cos(rad))), NB'($rtoi(16384.0 * $sin(rad))));
      send_normal(NB'(-$rtoi(16384.0 * $cos(rad))), NB'(-$rtoi(16384.0 * $sin(rad))));
      drain_results();
    end
  endtask

  // Random normals, with a fresh light direction every 125 requests.
  task automatic test_random_normals(input int n, input int s_pct, input int r_pct);
    int                   kind;
    int                   tx, ty;
    logic signed [NB-1:0] nx, ny;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int k = 0; k < n; k++) begin
      if (k % 125 == 0) begin
        drain_results();
        write_light(LIGHT_W'($urandom_range(511)));
      end
      kind = $urandom_range(9);
      if (kind < 4) begin
        // full 16-bit range, every bit pattern
        nx = NB'($urandom);
        ny = NB'($urandom);
      end else if (kind < 8) begin
        // normals in the valid Q1.14 range
        tx = int'($urandom_range(32768)) - 16384;
        ty = int'($urandom_range(32768)) - 16384;
        nx = NB'(tx);
        ny = NB'(ty);
      end else if (kind == 8) begin
        nx = '0;
        ny = NB'($urandom);
      end else begin
        // tiny vectors near the origin
        tx = int'($urandom_range(6)) - 3;
        ty = int'($urandom_range(6)) - 3;
        nx = NB'(tx);
        ny = NB'(ty);
      end
      send_normal(nx, ny);
    end
    drain_results();
  endtask

  // Hold the receiver off for a long stretch while requests keep coming, so
  // the pipeline fills and in_ready drops.
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_len = 200;
    hold_req = hold_req + 1;
    for (int k = 0; k < 80; k++)
      send_normal(NB'($urandom), NB'($urandom));
    drain_results();
  endtask

  // Pause the sender until every result is back, then resume.
  task automatic test_sender_pause();
    send_idle_pct = 10;
    recv_idle_pct = 30;
    for (int k = 0; k < 30; k++)
      send_normal(NB'($urandom), NB'($urandom));
    in_valid <= 1'b0;
    while (shade_expect_q.size() != 0) @(posedge clk);
    for (int k = 0; k < 30; k++)
      send_normal(NB'($urandom), NB'($urandom));
    drain_results();
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = hold_len;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= (int'($urandom_range(99)) >= recv_idle_pct);
    end
  end

  // Compare each taken result against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (shade_expect_q.size() == 0) begin
        $error("shade result %0d arrived with no request outstanding", out_shade);
        mismatch_count++;
      end else begin
        shade_exp = shade_expect_q.pop_front();
        if (out_shade !== shade_exp) begin
          $error("shade mismatch: expected %0d, actual %0d", shade_exp, out_shade);
          mismatch_count++;
        end
      end
    end
  end

  // Guard against a hang.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_normals();
    test_light_settings();
    test_random_normals(440, 35, 64);
    test_random_normals(440, 64, 35);
    test_random_normals(400, 0, 0);
    test_output_backpressure();
    test_sender_pause();
    // Let any stray result show up before judging.
    repeat (STAGES + 10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* files.f */
+incdir+src
src/nasf_pkg.sv
src/nasf_prep.sv
src/nasf_cordic_stage.sv
src/nasf_shade.sv
src/normal_angle_shade_factor.sv
tb/normal_angle_shade_factor_tb.sv
